// File: rtl/core/ple_pkg.sv
// Package for the positional list engine: command and result beat types,
// opcode and status codes, and the control word broadcast to the cell chain.
// No dependencies.
`timescale 1ns / 1ps

package ple_pkg;

	localparam int COUNT_W = 7;
	localparam int DATA_W  = 32;

	localparam logic [1:0] OP_CLEAR  = 2'd0;
	localparam logic [1:0] OP_INSERT = 2'd1;
	localparam logic [1:0] OP_DELETE = 2'd2;
	localparam logic [1:0] OP_DUMP   = 2'd3;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_BADPOS = 2'd1;
	localparam logic [1:0] ST_FULL   = 2'd2;

	typedef struct packed {
		logic [1:0]                opcode;
		logic [COUNT_W-1:0]        position;
		logic signed [DATA_W-1:0]  value;
	} cmd_t;

	typedef struct packed {
		logic [1:0]                status;
		logic signed [DATA_W-1:0]  item;
		logic                      has_item;
		logic                      last;
		logic [COUNT_W-1:0]        length;
	} result_t;

	typedef enum logic [1:0] {
		CM_HOLD,
		CM_INSERT,
		CM_DELETE,
		CM_ROTATE
	} cell_mode_t;

	typedef struct packed {
		cell_mode_t                mode;
		logic [COUNT_W-1:0]        pos_idx;   // zero-based target position
		logic [COUNT_W-1:0]        tail_idx;  // index of the last live entry
		logic signed [DATA_W-1:0]  value;
	} cell_ctrl_t;

endpackage

// File: rtl/core/ple_cell.sv
// One storage cell of the list chain: holds one entry and takes its next
// value from itself, its left or right neighbor, the head, or the insert value.
// Depends on ple_pkg.
`timescale 1ns / 1ps

module ple_cell import ple_pkg::*; #(
	parameter int IDX = 0
) (
	input  logic                      clk,
	input  cell_ctrl_t                ctrl,
	input  logic signed [DATA_W-1:0]  left_data,
	input  logic signed [DATA_W-1:0]  right_data,
	input  logic signed [DATA_W-1:0]  head_data,
	output logic signed [DATA_W-1:0]  data
);

	localparam logic [COUNT_W-1:0] IDX_C = COUNT_W'(IDX);

	logic signed [DATA_W-1:0] data_q;
	logic signed [DATA_W-1:0] data_next;

	always_comb begin
		data_next = data_q;
		case (ctrl.mode)
			CM_INSERT: begin
				// open a gap at the target, shift everything above it right
				if (IDX_C == ctrl.pos_idx) begin
					data_next = ctrl.value;
				end else if (IDX_C > ctrl.pos_idx) begin
					data_next = left_data;
				end
			end
			CM_DELETE: begin
				// close the gap: the target and all above pull from the right
				if (IDX_C >= ctrl.pos_idx) begin
					data_next = right_data;
				end
			end
			CM_ROTATE: begin
				// rotate the live part of the list by one toward the head
				if (IDX_C == ctrl.tail_idx) begin
					data_next = head_data;
				end else if (IDX_C < ctrl.tail_idx) begin
					data_next = right_data;
				end
			end
			default: begin
				data_next = data_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		data_q <= data_next;
	end

	assign data = data_q;

endmodule

// File: rtl/core/positional_list_engine_core.sv
// Top level of the positional list engine: command decode, list length,
// dump sequencer, result register and the chain of ple_cell storage cells.
// Depends on ple_pkg and ple_cell.
`timescale 1ns / 1ps

// Ordered list of up to CAPACITY signed 32-bit entries addressed by 1-based
// position. A command beat is taken when start is high and busy is low.
// Clear, insert and delete never raise busy: their single result appears
// on result with result_valid high in the cycle right after the command, and
// a new command may be issued in that same cycle. Insert and delete shift
// every cell of the chain at once, so their cost does not depend on the list
// length. A dump of n entries holds busy high while in the dump state and
// emits one result per cycle, the first when the result register has taken
// the head entry and the last in the same cycle as busy drops; the entries
// leave the head of the chain while the live part of the chain rotates by
// one, so once all n entries have gone out the list is back in order. An
// empty dump gives one result with has_item low in the cycle right after the
// command. Every result carries last, the list length after the command, and
// a status (ok, bad position, list full; bad position wins).
// result_valid is high for exactly one cycle per result and there is no
// back-pressure: the receiver must take every result when it is shown.
// Entries beyond the current length hold stale data and are never shown.

module positional_list_engine_core import ple_pkg::*; #(
	parameter int CAPACITY = 64
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	output logic    busy,
	input  cmd_t    cmd,
	output logic    result_valid,
	output result_t result
);

	localparam logic [COUNT_W-1:0] CAP_C = COUNT_W'(CAPACITY);

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_DUMP = 2'b10
	} state_t;

	state_t                   state_q;
	logic [COUNT_W-1:0]       count_q;
	logic [COUNT_W-1:0]       dump_idx_q;
	logic                     result_valid_q;
	result_t                  result_q;

	logic                     accept;
	logic                     pos_zero;
	logic                     ins_bad;
	logic                     del_bad;
	logic                     is_full;
	logic [COUNT_W-1:0]       tail_idx;
	logic                     dump_last;
	logic                     dump_start;
	cell_ctrl_t               ctrl;

	logic signed [DATA_W-1:0] cell_data [CAPACITY];

	assign busy   = (state_q == S_DUMP);
	assign accept = start && !busy;

	// position checks; count never exceeds CAPACITY (64 by default) so count + 1 fits the width
	assign pos_zero  = (cmd.position == '0);
	assign ins_bad   = pos_zero || (cmd.position > (count_q + COUNT_W'(1)));
	assign del_bad   = pos_zero || (cmd.position > count_q);
	assign is_full   = (count_q == CAP_C);
	assign tail_idx  = count_q - COUNT_W'(1);
	assign dump_last = (dump_idx_q == tail_idx);

	// a dump of a non-empty list streams; everything else answers at once
	assign dump_start = accept && (cmd.opcode == OP_DUMP) && (count_q != '0);

	// broadcast control word for the chain
	always_comb begin
		ctrl.mode     = CM_HOLD;
		ctrl.pos_idx  = cmd.position - COUNT_W'(1);
		ctrl.tail_idx = tail_idx;
		ctrl.value    = cmd.value;
		if (busy) begin
			ctrl.mode = CM_ROTATE;
		end else if (accept) begin
			case (cmd.opcode)
				OP_INSERT: begin
					if (!ins_bad && !is_full) begin
						ctrl.mode = CM_INSERT;
					end
				end
				OP_DELETE: begin
					if (!del_bad) begin
						ctrl.mode = CM_DELETE;
					end
				end
				default: begin
					ctrl.mode = CM_HOLD;
				end
			endcase
		end
	end

	// chain of cells; the ends see zero from the missing neighbor
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic signed [DATA_W-1:0] left_d;
		logic signed [DATA_W-1:0] right_d;

		if (i == 0) begin : g_first
			assign left_d = '0;
		end else begin : g_mid_l
			assign left_d = cell_data[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign right_d = '0;
		end else begin : g_mid_r
			assign right_d = cell_data[i+1];
		end

		ple_cell #(
			.IDX (i)
		) u_cell (
			.clk        (clk),
			.ctrl       (ctrl),
			.left_data  (left_d),
			.right_data (right_d),
			.head_data  (cell_data[0]),
			.data       (cell_data[i])
		);
	end

	// control: state, length, dump counter, strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			count_q        <= '0;
			dump_idx_q     <= '0;
			result_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					// answer at once unless a dump starts streaming
					result_valid_q <= accept && !dump_start;
					if (accept) begin
						case (cmd.opcode)
							OP_CLEAR: begin
								count_q <= '0;
							end
							OP_INSERT: begin
								if (!ins_bad && !is_full) begin
									count_q <= count_q + COUNT_W'(1);
								end
							end
							OP_DELETE: begin
								if (!del_bad) begin
									count_q <= count_q - COUNT_W'(1);
								end
							end
							default: begin
								// dump: stream entries, or answer empty at once
								if (count_q != '0) begin
									dump_idx_q <= '0;
									state_q    <= S_DUMP;
								end
							end
						endcase
					end
				end
				S_DUMP: begin
					result_valid_q <= 1'b1;
					dump_idx_q     <= dump_idx_q + COUNT_W'(1);
					if (dump_last) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					result_valid_q <= 1'b0;
					state_q        <= S_IDLE;
				end
			endcase
		end
	end

	// result payload; no reset needed, qualified by the strobe
	always_ff @(posedge clk) begin
		if (busy) begin
			result_q.status   <= ST_OK;
			result_q.item     <= cell_data[0];
			result_q.has_item <= 1'b1;
			result_q.last     <= dump_last;
			result_q.length   <= count_q;
		end else if (accept) begin
			result_q.item     <= '0;
			result_q.has_item <= 1'b0;
			result_q.last     <= 1'b1;
			case (cmd.opcode)
				OP_CLEAR: begin
					result_q.status <= ST_OK;
					result_q.length <= '0;
				end
				OP_INSERT: begin
					if (ins_bad) begin
						result_q.status <= ST_BADPOS;
						result_q.length <= count_q;
					end else if (is_full) begin
						result_q.status <= ST_FULL;
						result_q.length <= count_q;
					end else begin
						result_q.status <= ST_OK;
						result_q.length <= count_q + COUNT_W'(1);
					end
				end
				OP_DELETE: begin
					if (del_bad) begin
						result_q.status <= ST_BADPOS;
						result_q.length <= count_q;
					end else begin
						result_q.status <= ST_OK;
						result_q.length <= count_q - COUNT_W'(1);
					end
				end
				default: begin
					result_q.status <= ST_OK;
					result_q.length <= count_q;
				end
			endcase
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	// a dump never runs on an empty list and its index stays inside the list
	a_dump_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> (count_q != '0) && (dump_idx_q < count_q))
		else $error("dump index outside the live list");

	// the length never exceeds the capacity
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CAP_C)
		else $error("list length beyond capacity");

	// leaving a dump shows the final beat of that dump
	a_dump_end: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> result_valid && result.last && result.has_item)
		else $error("dump ended without its final beat");

	// mid-dump beats are not marked last and carry an entry
	a_dump_mid: assert property (@(posedge clk) disable iff (!arst_n)
		(busy && $past(busy)) |-> result_valid && !result.last && result.has_item)
		else $error("dump beat malformed");

	// an entry is only shown with ok status
	a_item_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.has_item) |-> (result.status == ST_OK))
		else $error("entry shown with error status");

endmodule
